[sv/smha_pkg.sv]
// Types, opcodes and constants shared by the sign-magnitude hex ALU.
package smha_pkg;

    // Number of hex digits in a magnitude and the derived widths.
    localparam int Digits = 8;
    localparam int MagW   = 4 * Digits;
    localparam int FieldW = 32;
    localparam int ShiftW = $clog2(Digits + 1);

    // Bits of a magnitude field that take part in the arithmetic.
    localparam logic [FieldW-1:0] MagMask =
        (MagW >= FieldW) ? {FieldW{1'b1}} : FieldW'((64'd1 << MagW) - 64'd1);

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_EQ  = 4'd2,
        OP_NE  = 4'd3,
        OP_GT  = 4'd4,
        OP_LT  = 4'd5,
        OP_GE  = 4'd6,
        OP_LE  = 4'd7,
        OP_SHL = 4'd8,
        OP_SHR = 4'd9,
        OP_ODD = 4'd10
    } t_op;

    // Work class decided by the front end.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ARITH,
        KIND_COND,
        KIND_SHL,
        KIND_SHR
    } t_kind;

    typedef struct packed {
        logic [3:0]        operation;
        logic              a_sign;
        logic [FieldW-1:0] a_magnitude;
        logic              b_sign;
        logic [FieldW-1:0] b_magnitude;
        logic [3:0]        shift_digits;
    } t_in_item;

    typedef struct packed {
        logic              result_sign;
        logic [FieldW-1:0] result_magnitude;
        logic              condition;
        logic              overflow;
    } t_out_item;

    // Classified item passed from front end to back end.
    typedef struct packed {
        t_kind             kind;
        logic              sign_a;     // normalised for arith, raw for shifts
        logic              sign_b;     // effective sign of b for add/sub
        logic [FieldW-1:0] mag_a;
        logic [FieldW-1:0] mag_b;
        logic              a_ge_b;     // magnitude compare
        logic [ShiftW-1:0] shift;      // clamped digit count
        logic              condition;  // compare / odd outcome
    } t_work;

    // Handshake between the work queue and the back end.
    typedef struct packed {
        logic valid;
        logic take;
    } t_qctl;

endpackage

[sv/smha_front.sv]
// Front end: masks operands, normalises zero signs, runs compares, classifies the item.
module smha_front (
    input  smha_pkg::t_in_item i_item,
    output smha_pkg::t_work    o_work
);

    logic [smha_pkg::FieldW-1:0] am;
    logic [smha_pkg::FieldW-1:0] bm;
    logic                        nas;
    logic                        nbs;
    logic                        mag_gt;
    logic                        mag_eq;
    logic                        a_gt_b;
    logic                        b_gt_a;
    logic                        eq;
    smha_pkg::t_op               op;

    assign am  = i_item.a_magnitude & smha_pkg::MagMask;
    assign bm  = i_item.b_magnitude & smha_pkg::MagMask;
    // negative zero counts as +0
    assign nas = i_item.a_sign & (am != '0);
    assign nbs = i_item.b_sign & (bm != '0);

    assign mag_gt = am > bm;
    assign mag_eq = am == bm;
    assign eq     = (nas == nbs) && mag_eq;
    assign a_gt_b = (nas != nbs) ? !nas : (nas ? (!mag_gt && !mag_eq) : mag_gt);
    assign b_gt_a = (nas != nbs) ? !nbs : (nas ? mag_gt : (!mag_gt && !mag_eq));

    assign op = smha_pkg::t_op'(i_item.operation);

    always_comb begin
        o_work           = '0;
        o_work.mag_a     = am;
        o_work.mag_b     = bm;
        o_work.a_ge_b    = mag_gt || mag_eq;
        o_work.sign_a    = nas;
        o_work.sign_b    = nbs;
        if (int'(i_item.shift_digits) > smha_pkg::Digits) begin
            o_work.shift = smha_pkg::ShiftW'(smha_pkg::Digits);
        end else begin
            o_work.shift = smha_pkg::ShiftW'(i_item.shift_digits);
        end
        unique case (op)
            smha_pkg::OP_ADD: begin
                o_work.kind = smha_pkg::KIND_ARITH;
            end
            smha_pkg::OP_SUB: begin
                o_work.kind   = smha_pkg::KIND_ARITH;
                // subtracting zero keeps a positive subtrahend
                o_work.sign_b = (bm != '0) & ~nbs;
            end
            smha_pkg::OP_EQ: begin
                o_work.kind      = smha_pkg::KIND_COND;
                o_work.condition = eq;
            end
            smha_pkg::OP_NE: begin
                o_work.kind      = smha_pkg::KIND_COND;
                o_work.condition = !eq;
            end
            smha_pkg::OP_GT: begin
                o_work.kind      = smha_pkg::KIND_COND;
                o_work.condition = a_gt_b;
            end
            smha_pkg::OP_LT: begin
                o_work.kind      = smha_pkg::KIND_COND;
                o_work.condition = b_gt_a;
            end
            smha_pkg::OP_GE: begin
                o_work.kind      = smha_pkg::KIND_COND;
                o_work.condition = !b_gt_a;
            end
            smha_pkg::OP_LE: begin
                o_work.kind      = smha_pkg::KIND_COND;
                o_work.condition = !a_gt_b;
            end
            smha_pkg::OP_SHL: begin
                o_work.kind   = smha_pkg::KIND_SHL;
                o_work.sign_a = i_item.a_sign;
            end
            smha_pkg::OP_SHR: begin
                o_work.kind   = smha_pkg::KIND_SHR;
                o_work.sign_a = i_item.a_sign;
            end
            smha_pkg::OP_ODD: begin
                o_work.kind      = smha_pkg::KIND_COND;
                o_work.condition = am[0];
            end
            default: begin
                o_work.kind = smha_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

[sv/smha_queue.sv]
// Two-entry queue of classified items between front end and back end.
module smha_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  smha_pkg::t_work  i_data,
    output logic             o_full,
    output smha_pkg::t_qctl  o_ctl_valid,
    input  logic             i_take,
    output smha_pkg::t_work  o_data
);

    smha_pkg::t_work r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;
    logic            n_wr;
    logic            n_rd;
    logic [1:0]      n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full            = r_count == 2'd2;
    assign o_ctl_valid.valid = r_count != 2'd0;
    assign o_ctl_valid.take  = do_pop;
    assign o_data            = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && (r_count != 2'd0);

    always_comb begin
        n_wr    = r_wr ^ do_push;
        n_rd    = r_rd ^ do_pop;
        n_count = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[sv/smha_back.sv]
// Back end: add/sub, digit shifts, result formatting and the two-entry result queue.
module smha_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smha_pkg::t_qctl     i_qctl,
    input  smha_pkg::t_work     i_work,
    output logic                o_take,
    input  logic                i_pop,
    output logic                o_empty,
    output smha_pkg::t_out_item o_item
);

    smha_pkg::t_out_item         r_mem [2];
    logic                        r_wr;
    logic                        r_rd;
    logic [1:0]                  r_count;
    logic [1:0]                  n_count;
    smha_pkg::t_out_item         res;
    logic [smha_pkg::FieldW:0]   sum;
    logic [smha_pkg::FieldW-1:0] diff_ab;
    logic [smha_pkg::FieldW-1:0] diff_ba;
    logic [smha_pkg::ShiftW+1:0] amt;
    logic                        do_pop;

    assign sum     = {1'b0, i_work.mag_a} + {1'b0, i_work.mag_b};
    assign diff_ab = i_work.mag_a - i_work.mag_b;
    assign diff_ba = i_work.mag_b - i_work.mag_a;
    assign amt     = {i_work.shift, 2'b00};

    always_comb begin
        res = '0;
        unique case (i_work.kind)
            smha_pkg::KIND_ARITH: begin
                if (i_work.sign_a == i_work.sign_b) begin
                    res.overflow         = sum > {1'b0, smha_pkg::MagMask};
                    res.result_magnitude = sum[smha_pkg::FieldW-1:0] & smha_pkg::MagMask;
                    res.result_sign      = i_work.sign_a;
                end else if (i_work.a_ge_b) begin
                    res.result_magnitude = diff_ab;
                    res.result_sign      = i_work.sign_a;
                end else begin
                    res.result_magnitude = diff_ba;
                    res.result_sign      = i_work.sign_b;
                end
                // zero is positive unless the sum wrapped
                if (res.result_magnitude == '0 && !res.overflow) begin
                    res.result_sign = 1'b0;
                end
            end
            smha_pkg::KIND_COND: begin
                res.condition = i_work.condition;
            end
            smha_pkg::KIND_SHL: begin
                res.result_magnitude = (i_work.mag_a << amt) & smha_pkg::MagMask;
                res.result_sign      = i_work.sign_a;
            end
            smha_pkg::KIND_SHR: begin
                res.result_magnitude = i_work.mag_a >> amt;
                res.result_sign      = i_work.sign_a;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // move one item per cycle while the result queue has room
    assign o_take  = i_qctl.valid && (r_count != 2'd2);
    assign o_empty = r_count == 2'd0;
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;
    assign n_count = r_count + 2'(i_qctl.take) - 2'(do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= r_wr ^ i_qctl.take;
            r_rd    <= r_rd ^ do_pop;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_qctl.take) begin
            r_mem[r_wr] <= res;
        end
    end

endmodule

[sv/sign_magnitude_hex_alu_unit.sv]
// Sign-magnitude hex ALU: add, subtract, compare, digit shifts and odd test.
// Path: an item is written into the work queue, then moved into the result queue, which drives o_item.
// Throughput: one item per cycle while full is low, held by the two-entry work and result queues.
// full rises only once the work queue holds two items the back end cannot move.
// Reset (synchronous, active low) empties both queues: full low, empty high.
module sign_magnitude_hex_alu_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  smha_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output smha_pkg::t_out_item o_item
);

    // classified item from the front end
    smha_pkg::t_work front_work;
    // head of the work queue
    smha_pkg::t_work queue_work;
    // work queue status towards the back end
    smha_pkg::t_qctl queue_ctl;
    // back end takes the queue head this cycle
    logic            back_take;

    // Front end: purely decode and compare; an item is classified in the
    // cycle of its input transfer and written into the work queue.
    smha_front u_front (
        .i_item (i_item),
        .o_work (front_work)
    );

    // Work queue: decouples acceptance from the back end, so input transfers
    // continue while a result waits to be popped.
    smha_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (front_work),
        .o_full      (full),
        .o_ctl_valid (queue_ctl),
        .i_take      (back_take),
        .o_data      (queue_work)
    );

    // Back end: an adder, two subtractors and left/right shifters, result into its own queue.
    smha_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qctl  (queue_ctl),
        .i_work  (queue_work),
        .o_take  (back_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_item)
    );

endmodule

[sv/smha_checker.sv]
// Port-level checker for the sign-magnitude hex ALU, bound to the top level.
module smha_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input smha_pkg::t_in_item  i_item,
    input logic                empty,
    input logic                pop,
    input smha_pkg::t_out_item o_item
);

    // reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // compare and odd results carry no magnitude, sign or overflow
    a_cond_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.condition) |->
            (o_item.result_magnitude == '0 && !o_item.result_sign && !o_item.overflow))
        else $error("condition result with arithmetic fields set");

    // overflow comes only from add/sub, never with a condition
    a_ovf_no_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.overflow) |-> !o_item.condition)
        else $error("overflow together with condition");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("waiting result changed or vanished");

endmodule

bind sign_magnitude_hex_alu_unit smha_checker u_smha_checker (.*);

[tb/tb_sign_magnitude_hex_alu_unit.sv]
// Self-checking testbench for the sign-magnitude hex ALU unit.
module tb_sign_magnitude_hex_alu_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import smha_pkg::*;

    // Codes outside the defined set; the unit must answer them with all-zero results.
    localparam logic [3:0] OP_UNDEF_LO = 4'd11;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;

    localparam int CYCLE_LIMIT = 200000;  // several times the slowest legal run
    localparam int HOLD_CYCLES = 80;      // long receiver hold-off for the pressure test
    localparam int DRAIN_CYCLES = 8;      // margin after the drain for any stray result

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_item   i_item;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_item;

    // Results still owed by the unit, oldest first.
    t_out_item  pending_results[$];
    int         mismatch_count = 0;

    // Idle control for both sides; cleared for the back-to-back stretch.
    bit         send_gaps = 1'b1;
    bit         recv_gaps = 1'b1;

    // Hold-off requests: the test bumps hold_asked, the receiver counts the cycles itself.
    int         hold_asked = 0;
    int         hold_taken = 0;
    int         hold_left = 0;

    sign_magnitude_hex_alu_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Signed a > b on normalised operands (zero already positive).
    function automatic logic signed_gt(logic as, logic [FieldW-1:0] am,
                                       logic bs, logic [FieldW-1:0] bm);
        if (as != bs)
            return (as == 1'b0);
        if (as == 1'b0)
            return (am > bm);
        return (am < bm);
    endfunction

    function automatic t_out_item alu_predict(t_in_item it);
        t_out_item         r;
        logic [FieldW-1:0] am;
        logic [FieldW-1:0] bm;
        logic              nas;
        logic              nbs;
        logic              es;
        logic [FieldW:0]   sum;
        logic [63:0]       wide;
        int                sh;
        r = '0;
        // Bits above the digit width take no part.
        am = it.a_magnitude & MagMask;
        bm = it.b_magnitude & MagMask;
        // Negative zero counts as +0.
        nas = (am == '0) ? 1'b0 : it.a_sign;
        nbs = (bm == '0) ? 1'b0 : it.b_sign;
        case (it.operation)
            OP_ADD, OP_SUB: begin
                es = (it.operation == OP_SUB) ? ~nbs : nbs;
                if (bm == '0)
                    es = 1'b0;
                if (nas == es) begin
                    sum = {1'b0, am} + {1'b0, bm};
                    r.overflow = (sum > {1'b0, MagMask});
                    r.result_magnitude = sum[FieldW-1:0] & MagMask;
                    r.result_sign = nas;
                end else if (am >= bm) begin
                    r.result_magnitude = am - bm;
                    r.result_sign = nas;
                end else begin
                    r.result_magnitude = bm - am;
                    r.result_sign = es;
                end
                // zero is positive unless the sum overflowed
                if (r.result_magnitude == '0 && !r.overflow)
                    r.result_sign = 1'b0;
            end
            OP_EQ: r.condition = (nas == nbs && am == bm);
            OP_NE: r.condition = !(nas == nbs && am == bm);
            OP_GT: r.condition = signed_gt(nas, am, nbs, bm);
            OP_LT: r.condition = signed_gt(nbs, bm, nas, am);
            OP_GE: r.condition = !signed_gt(nbs, bm, nas, am);
            OP_LE: r.condition = !signed_gt(nas, am, nbs, bm);
            OP_SHL, OP_SHR: begin
                sh = (it.shift_digits > Digits) ? Digits : int'(it.shift_digits);
                wide = {{(64-FieldW){1'b0}}, am};
                if (it.operation == OP_SHL)
                    wide = wide << (4 * sh);
                else
                    wide = wide >> (4 * sh);
                r.result_magnitude = wide[FieldW-1:0] & MagMask;
                r.result_sign = it.a_sign;  // sign kept even for a zero result
            end
            OP_ODD: r.condition = am[0];
            default: r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_in_item make_item(logic [3:0] op, logic as, logic [FieldW-1:0] am,
                                           logic bs, logic [FieldW-1:0] bm,
                                           logic [3:0] sd);
        t_in_item it;
        it.operation    = op;
        it.a_sign       = as;
        it.a_magnitude  = am;
        it.b_sign       = bs;
        it.b_magnitude  = bm;
        it.shift_digits = sd;
        return it;
    endfunction

    // Magnitudes biased towards zero, all ones, tiny values and single bits.
    function automatic logic [FieldW-1:0] pick_magnitude();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return FieldW'($urandom_range(15));
            3: return FieldW'(1) << $urandom_range(FieldW - 1);
            default: return FieldW'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    // push is left high so back-to-back items never see a low pulse.
    task automatic send_item(t_in_item it);
        while (send_gaps && $urandom_range(99) < 33) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        pending_results.push_back(alu_predict(it));
        @(negedge i_clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 5)
            it.operation = 4'($urandom_range(15, 11));  // undefined codes
        else
            it.operation = 4'($urandom_range(10));
        it.a_sign       = 1'($urandom);
        it.a_magnitude  = pick_magnitude();
        it.b_sign       = 1'($urandom);
        it.b_magnitude  = pick_magnitude();
        it.shift_digits = 4'($urandom_range(15));
        // Equal magnitudes exercise the compare ties and exact cancellation.
        if ($urandom_range(3) == 0)
            it.b_magnitude = it.a_magnitude;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every operation and the corner cases.
    task automatic test_directed();
        send_item(make_item(OP_ADD, 1'b0, '1, 1'b0, 32'd1, 4'd0));         // overflow
        send_item(make_item(OP_ADD, 1'b1, '1, 1'b1, '1, 4'd0));            // negative overflow
        send_item(make_item(OP_ADD, 1'b0, 32'd5, 1'b1, 32'd5, 4'd0));      // cancels to +0
        send_item(make_item(OP_ADD, 1'b1, '0, 1'b1, '0, 4'd0));            // two negative zeros
        send_item(make_item(OP_SUB, 1'b1, '0, 1'b1, '0, 4'd0));
        send_item(make_item(OP_SUB, 1'b0, 32'd3, 1'b0, 32'd7, 4'd0));      // sign flips
        send_item(make_item(OP_SUB, 1'b1, '1, 1'b0, 32'd1, 4'd0));         // overflow via sub
        send_item(make_item(OP_SUB, 1'b0, 32'h8000_0000, 1'b1, 32'h8000_0000, 4'd0));
        send_item(make_item(OP_EQ, 1'b1, '0, 1'b0, '0, 4'd0));             // -0 equals +0
        send_item(make_item(OP_NE, 1'b0, 32'd1, 1'b1, 32'd1, 4'd0));
        send_item(make_item(OP_GT, 1'b1, 32'd1, 1'b1, 32'd2, 4'd0));
        send_item(make_item(OP_LT, 1'b0, '0, 1'b1, '0, 4'd0));
        send_item(make_item(OP_GE, 1'b0, '1, 1'b0, '1, 4'd0));
        send_item(make_item(OP_LE, 1'b1, '1, 1'b0, '1, 4'd0));
        send_item(make_item(OP_SHL, 1'b0, 32'h1234_5678, 1'b0, '0, 4'd0));
        send_item(make_item(OP_SHL, 1'b1, 32'h1234_5678, 1'b0, '0, 4'd8)); // keeps sign at 0
        send_item(make_item(OP_SHL, 1'b0, '1, 1'b1, '1, 4'd9));            // clamped count
        send_item(make_item(OP_SHR, 1'b1, '1, 1'b0, '0, 4'd15));           // clamped count
        send_item(make_item(OP_SHR, 1'b0, 32'hDEAD_BEEF, 1'b0, '0, 4'd3));
        send_item(make_item(OP_ODD, 1'b0, '1, 1'b0, '0, 4'd0));
        send_item(make_item(OP_ODD, 1'b1, '0, 1'b1, '1, 4'd0));
        send_item(make_item(OP_UNDEF_LO, 1'b1, '1, 1'b1, '1, 4'd15));
        send_item(make_item(OP_UNDEF_HI, 1'b1, '1, 1'b1, '1, 4'd15));
    endtask

    // Bulk random traffic with random idling on both sides.
    task automatic test_random_mix(int count);
        repeat (count)
            send_item(random_item());
    endtask

    // Long stretch with neither side idling.
    task automatic test_back_to_back(int count);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (count)
            send_item(random_item());
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, so full must assert.
    task automatic test_full_pressure(int count);
        send_gaps = 1'b0;
        hold_asked = hold_asked + 1;
        repeat (count)
            send_item(random_item());
        send_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: pop driven at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end else if (recv_gaps) begin
            pop <= ($urandom_range(99) >= 33);
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each output transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_item);
            end else begin
                want = pending_results.pop_front();
                if (o_item.result_sign !== want.result_sign) begin
                    mismatch_count++;
                    $display("%0t: result_sign expected %b actual %b",
                             $time, want.result_sign, o_item.result_sign);
                end
                if (o_item.result_magnitude !== want.result_magnitude) begin
                    mismatch_count++;
                    $display("%0t: result_magnitude expected %h actual %h",
                             $time, want.result_magnitude, o_item.result_magnitude);
                end
                if (o_item.condition !== want.condition) begin
                    mismatch_count++;
                    $display("%0t: condition expected %b actual %b",
                             $time, want.condition, o_item.condition);
                end
                if (o_item.overflow !== want.overflow) begin
                    mismatch_count++;
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.overflow, o_item.overflow);
                end
            end
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_mix(630);
        test_back_to_back(150);
        test_full_pressure(100);

        push <= 1'b0;
        // drain, then wait out the drain margin for any stray result to show
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
